// ----- src/csv_field_tokenizer_assert.svh -----
// Assertion macros used by the checker file of the tokenizer.
`ifndef CSV_FIELD_TOKENIZER_ASSERT_SVH
`define CSV_FIELD_TOKENIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/cft_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cft_pkg
// Types, codes and constants of the CSV field tokenizer.
// ----------------------------------------------------------------------------
package cft_pkg;

  localparam int MAX_FIELDS = 256;
  localparam logic [7:0] FIELD_LIMIT =
    (MAX_FIELDS - 1 < 255) ? 8'(MAX_FIELDS - 1) : 8'd255;
  localparam logic [6:0] QUOTED_EOL_LIMIT = 7'd100;
  localparam logic [6:0] QEOL_MAX         = 7'd127;

  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;

  localparam logic [7:0] SEP_RESET   = 8'd44;
  localparam logic [7:0] QUOTE_RESET = 8'd34;
  localparam logic [7:0] EOL_RESET   = 8'd10;

  localparam logic [1:0] QM_DOUBLED = 2'd0;
  localparam logic [1:0] QM_ESCAPED = 2'd1;
  localparam logic [1:0] QM_NONE    = 2'd2;

  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_STRAY     = 2'd1;
  localparam logic [1:0] ERR_UNTERM    = 2'd2;
  localparam logic [1:0] ERR_EOL_LIMIT = 2'd3;

  typedef enum logic [2:0] {
    REG_SEP   = 3'd0,
    REG_QUOTE = 3'd1,
    REG_EOL   = 3'd2,
    REG_PAIR  = 3'd3,
    REG_QMODE = 3'd4,
    REG_STRIP = 3'd5,
    REG_SKIP  = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_FSTART = 3'd0,
    PH_FLEAD  = 3'd1,
    PH_SEPRUN = 3'd2,
    PH_BLANK  = 3'd3,
    PH_UNQ    = 3'd4,
    PH_INQ    = 3'd5,
    PH_QSEEN  = 3'd6,
    PH_AFTERQ = 3'd7
  } phase_t;

  typedef struct packed {
    logic [7:0] separator_byte;
    logic [7:0] quote_byte;
    logic [7:0] eol_byte;
    logic       eol_pair;
    logic [1:0] quote_mode;
    logic       strip_white;
    logic       skip_blank_lines;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_content;
    logic       field_end;
    logic       record_end;
    logic [7:0] field_index;
    logic [1:0] error_code;
  } res_t;

  typedef struct packed {
    phase_t     phase;
    logic       content;
    logic       bump;
    logic       fend_last;
    logic       rend;
    logic       endrec;
    logic [1:0] err;
    logic       qeol_clr;
    logic       qeol_inc;
    logic       esc_set;
    logic       esc_clr;
    logic       eol2_set;
    logic       clear;
  } dec_t;

endpackage

// ----- src/csv_field_tokenizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_field_tokenizer
// Streaming CSV byte classifier with configurable separator, quote and
// end-of-line bytes.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while in_tready is high and returns one registered
// result per byte. Each byte is decided combinationally by the parse phase
// state machine in cft_core; the result sits in an output register backed by
// a one-entry skid register, so in_tready stays high while out_tready is high
// and drops only after the skid entry fills. Configuration writes are taken
// every cycle and must be issued while the stream is idle.
module csv_field_tokenizer import cft_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // end_of_input
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] data_byte, [15:8] field_index,
                                  // [17:16] error_code, [23:18] zero
  output logic [1:0]  out_tuser,  // [0] is_content, [1] field_end
  output logic        out_tlast,  // record_end
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [7:0]  cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  res_t res;
  res_t main_r, main_nxt, skid_r, skid_nxt;
  logic main_valid_r, main_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic push, pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_addr))
        REG_SEP:   cfg_nxt.separator_byte   = cfg_data;
        REG_QUOTE: cfg_nxt.quote_byte       = cfg_data;
        REG_EOL:   cfg_nxt.eol_byte         = cfg_data;
        REG_PAIR:  cfg_nxt.eol_pair         = cfg_data[0];
        REG_QMODE: cfg_nxt.quote_mode       = cfg_data[1:0];
        REG_STRIP: cfg_nxt.strip_white      = cfg_data[0];
        REG_SKIP:  cfg_nxt.skip_blank_lines = cfg_data[0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.separator_byte   <= SEP_RESET;
      cfg_r.quote_byte       <= QUOTE_RESET;
      cfg_r.eol_byte         <= EOL_RESET;
      cfg_r.eol_pair         <= 1'b0;
      cfg_r.quote_mode       <= QM_DOUBLED;
      cfg_r.strip_white      <= 1'b1;
      cfg_r.skip_blank_lines <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_tready = !skid_valid_r;
  assign push      = in_tvalid && in_tready;
  assign pop       = main_valid_r && out_tready;

  cft_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (push),
    .in_byte      (in_tdata),
    .end_of_input (in_tlast),
    .cfg          (cfg_r),
    .res          (res)
  );

  // Output register plus skid entry; the skid is empty whenever an item is pushed.
  always_comb begin
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = res;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = main_valid_r;
  assign out_tdata  = {6'b0, main_r.error_code, main_r.field_index, main_r.data_byte};
  assign out_tuser  = {main_r.field_end, main_r.is_content};
  assign out_tlast  = main_r.record_end;

endmodule

// ----- src/cft_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cft_core
// Per-byte parse state machine: classifies one byte per step and advances
// the phase, field counter, quoted end-of-line count and pending flags.
// ----------------------------------------------------------------------------
module cft_core import cft_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  input  cfg_t       cfg,
  output res_t       res
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] fcnt_r, fcnt_nxt;
  logic [6:0] qeol_r, qeol_nxt;
  logic       eol2_r, eol2_nxt;
  logic       esc_r, esc_nxt;

  dec_t d;

  logic is_eol, is_quote, is_ws, is_sep, is_space, sep_is_space;

  assign is_eol       = (in_byte == cfg.eol_byte);
  assign is_quote     = (in_byte == cfg.quote_byte);
  assign is_space     = (in_byte == CHAR_SPACE);
  assign sep_is_space = (cfg.separator_byte == CHAR_SPACE);
  assign is_sep       = (cfg.separator_byte != cfg.eol_byte) &&
                        (in_byte == cfg.separator_byte);

  always_comb begin
    if (sep_is_space) begin
      is_ws = (in_byte == CHAR_TAB);
    end else if (cfg.separator_byte == CHAR_TAB) begin
      is_ws = is_space;
    end else begin
      is_ws = is_space || (in_byte == CHAR_TAB);
    end
  end

  // Decide what this byte does.
  always_comb begin : decide
    phase_t ph;
    logic   sw;
    ph = phase_r;
    sw = 1'b0;
    d  = '0;
    if (eol2_r) begin
      sw = 1'b1;
    end else begin
      if (ph == PH_BLANK) begin
        if (is_eol) begin
          d.eol2_set = cfg.eol_pair;
          sw = 1'b1;
        end else if (cfg.strip_white && is_ws) begin
          sw = 1'b1;
        end else begin
          ph = PH_FSTART;
        end
      end else if (ph == PH_SEPRUN) begin
        if (is_space) sw = 1'b1;
        else ph = PH_FSTART;
      end else if (ph == PH_QSEEN) begin
        if (is_quote) begin
          d.content = 1'b1;
          ph = PH_INQ;
          sw = 1'b1;
        end else begin
          ph = PH_AFTERQ;
        end
      end
      if (!sw) begin
        unique case (ph)
          PH_INQ: begin
            if (esc_r) begin
              d.esc_clr = 1'b1;
              d.content = 1'b1;
            end else if (qeol_r >= QUOTED_EOL_LIMIT) begin
              if (is_quote) begin
                d.content = 1'b1;
                ph = PH_AFTERQ;
              end else begin
                // Limit hit: continue as unquoted text.
                d.err = ERR_EOL_LIMIT;
                ph = PH_UNQ;
                if (is_eol) begin
                  d.bump = 1'b1;
                  d.endrec = 1'b1;
                end else if (is_sep) begin
                  d.bump = 1'b1;
                  ph = sep_is_space ? PH_SEPRUN : PH_FSTART;
                end else begin
                  d.content = 1'b1;
                end
              end
            end else if (is_quote) begin
              d.content = 1'b1;
              ph = (cfg.quote_mode == QM_DOUBLED) ? PH_QSEEN : PH_AFTERQ;
            end else begin
              d.content = 1'b1;
              if (is_eol && qeol_r < QEOL_MAX) d.qeol_inc = 1'b1;
              if (cfg.quote_mode == QM_ESCAPED && in_byte == CHAR_BSLASH) begin
                d.esc_set = 1'b1;
              end
            end
          end
          PH_UNQ: begin
            if (is_eol) begin
              d.bump = 1'b1;
              d.endrec = 1'b1;
            end else if (is_sep) begin
              d.bump = 1'b1;
              ph = sep_is_space ? PH_SEPRUN : PH_FSTART;
            end else begin
              d.content = 1'b1;
            end
          end
          PH_AFTERQ: begin
            if (cfg.strip_white && is_ws) begin
              d.content = 1'b0;
            end else if (is_eol) begin
              d.bump = 1'b1;
              d.endrec = 1'b1;
            end else if (is_sep) begin
              d.bump = 1'b1;
              ph = sep_is_space ? PH_SEPRUN : PH_FSTART;
            end else begin
              d.err = ERR_STRAY;
              d.content = 1'b1;
              ph = PH_UNQ;
            end
          end
          default: begin
            // Field start, with or without stripped lead white space.
            if (is_eol) begin
              if (ph == PH_FLEAD) d.bump = 1'b1;
              d.endrec = 1'b1;
            end else if (cfg.strip_white && is_ws) begin
              ph = PH_FLEAD;
            end else if (is_quote && cfg.quote_mode < QM_NONE) begin
              d.content  = 1'b1;
              ph = PH_INQ;
              d.qeol_clr = 1'b1;
              d.esc_clr  = 1'b1;
            end else if (is_sep) begin
              d.bump = 1'b1;
              ph = sep_is_space ? PH_SEPRUN : PH_FSTART;
            end else begin
              d.content = 1'b1;
              ph = PH_UNQ;
            end
          end
        endcase
        if (d.endrec) begin
          d.rend     = 1'b1;
          d.eol2_set = cfg.eol_pair;
          ph = cfg.skip_blank_lines ? PH_BLANK : PH_FSTART;
        end
      end
    end
    if (end_of_input) begin
      d.clear = 1'b1;
      if (!d.rend && ph != PH_BLANK && !(sw && ph != PH_SEPRUN)) begin
        if (ph == PH_INQ) begin
          if (d.err == ERR_OK) d.err = ERR_UNTERM;
          d.fend_last = 1'b1;
        end else if (ph != PH_FSTART && ph != PH_SEPRUN) begin
          d.fend_last = 1'b1;
        end
        d.rend = 1'b1;
      end
    end
    d.phase = ph;
  end

  // Next state.
  always_comb begin
    phase_nxt = d.phase;
    fcnt_nxt  = fcnt_r;
    qeol_nxt  = qeol_r;
    esc_nxt   = esc_r;
    eol2_nxt  = d.eol2_set;
    if (d.bump && fcnt_r < FIELD_LIMIT) fcnt_nxt = fcnt_r + 8'd1;
    if (d.endrec) fcnt_nxt = '0;
    if (d.qeol_clr) qeol_nxt = '0;
    else if (d.qeol_inc) qeol_nxt = qeol_r + 7'd1;
    if (d.esc_clr) esc_nxt = 1'b0;
    if (d.esc_set) esc_nxt = 1'b1;
    if (d.clear) begin
      phase_nxt = PH_FSTART;
      fcnt_nxt  = '0;
      qeol_nxt  = '0;
      esc_nxt   = 1'b0;
      eol2_nxt  = 1'b0;
    end
  end

  // Result of this byte.
  always_comb begin
    res.data_byte   = in_byte;
    res.is_content  = d.content;
    res.field_end   = d.bump | d.fend_last;
    res.record_end  = d.rend;
    res.field_index = fcnt_r;
    res.error_code  = d.err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FSTART;
      fcnt_r  <= '0;
      qeol_r  <= '0;
      eol2_r  <= 1'b0;
      esc_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      fcnt_r  <= fcnt_nxt;
      qeol_r  <= qeol_nxt;
      eol2_r  <= eol2_nxt;
      esc_r   <= esc_nxt;
    end
  end

endmodule

// ----- src/cft_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cft_checker
// Port-level assertions for the CSV field tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "csv_field_tokenizer_assert.svh"

module cft_checker import cft_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  `CFT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result item changed")
  `CFT_ASSERT_NOW(a_stall_full, !in_tready, out_tvalid, "input stalled with no result waiting")
  `CFT_ASSERT_NOW(a_unterm_ends, out_tvalid && out_tdata[17:16] == ERR_UNTERM, out_tuser[1] && out_tlast, "unterminated quote without field and record end")
  `CFT_ASSERT_NOW(a_stray_content, out_tvalid && out_tdata[17:16] == ERR_STRAY, out_tuser[0], "stray byte after quote not marked as content")

endmodule

bind csv_field_tokenizer cft_checker u_cft_checker (.*);
